[rtl/mbp_pkg.sv]
// Shared types, widths and constants for the Mandelbrot pixel membership block.
package mbp_pkg;

   // Fixed-point format of c and z
   localparam int FRAC_BITS = 28;
   localparam int Z_W       = 42;
   localparam int MAG_W     = FRAC_BITS + 2;
   localparam int PROD_W    = 2 * MAG_W;
   localparam int SQ_W      = FRAC_BITS + 3;
   localparam int CROSS_W   = FRAC_BITS + 4;

   // Field and register widths
   localparam int COORD_W = 8;
   localparam int EDGE_W  = 32;
   localparam int STEP_W  = 31;
   localparam int SPAN_W  = COORD_W + STEP_W;
   localparam int CNT_W   = 10;
   localparam int DATA_W  = 32;
   localparam int ADDR_W  = 5;

   localparam int MBP_QUEUE_DEPTH = 2;

   // Escape thresholds: component magnitude 2, squared sum 4
   localparam logic [Z_W-1:0]  TWO_MAG  = Z_W'(1) << (FRAC_BITS + 1);
   localparam logic [SQ_W:0]   FOUR_SUM = (SQ_W + 1)'(1) << (FRAC_BITS + 2);

   // Register reset values
   localparam logic [EDGE_W-1:0] MIN_RE_RST   = 32'hE000_0000;
   localparam logic [EDGE_W-1:0] MAX_IM_RST   = 32'd483183821;
   localparam logic [STEP_W-1:0] RE_STEP_RST  = 31'd5404784;
   localparam logic [STEP_W-1:0] IM_STEP_RST  = 31'd5404784;
   localparam logic [CNT_W-1:0]  MAX_ITER_RST = 10'd30;

   typedef enum logic [2:0] {
      REG_MIN_RE   = 3'd0,
      REG_MAX_IM   = 3'd1,
      REG_RE_STEP  = 3'd2,
      REG_IM_STEP  = 3'd3,
      REG_MAX_ITER = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      ENG_IDLE,
      ENG_MUL,
      ENG_UPD
   } eng_state_type;

   typedef struct packed {
      logic signed [EDGE_W-1:0] min_re;
      logic signed [EDGE_W-1:0] max_im;
      logic [STEP_W-1:0]        re_step;
      logic [STEP_W-1:0]        im_step;
      logic [CNT_W-1:0]         max_iter;
   } cfg_type;

   typedef struct packed {
      logic [COORD_W-1:0]    column;
      logic [COORD_W-1:0]    row;
      logic signed [Z_W-1:0] c_re;
      logic signed [Z_W-1:0] c_im;
   } item_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic one_left;
   } qstat_type;

endpackage

[rtl/mbp_csr.sv]
// Configuration register file behind the APB-style port.
module mbp_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [mbp_pkg::ADDR_W-1:0] paddr,
   input  logic [mbp_pkg::DATA_W-1:0] pwdata,
   output logic [mbp_pkg::DATA_W-1:0] prdata,
   output logic                       pready,
   output mbp_pkg::cfg_type           cfg
);
   import mbp_pkg::*;

   logic signed [EDGE_W-1:0] min_re_ff;
   logic signed [EDGE_W-1:0] max_im_ff;
   logic [STEP_W-1:0]        re_step_ff;
   logic [STEP_W-1:0]        im_step_ff;
   logic [CNT_W-1:0]         max_iter_ff;
   logic                     wr_en;
   reg_index_type            index;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign index  = reg_index_type'(paddr[ADDR_W-1:2]);

   // Write registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         min_re_ff   <= MIN_RE_RST;
         max_im_ff   <= MAX_IM_RST;
         re_step_ff  <= RE_STEP_RST;
         im_step_ff  <= IM_STEP_RST;
         max_iter_ff <= MAX_ITER_RST;
      end else if (wr_en) begin
         unique case (index)
            REG_MIN_RE:   min_re_ff   <= pwdata;
            REG_MAX_IM:   max_im_ff   <= pwdata;
            REG_RE_STEP:  re_step_ff  <= pwdata[STEP_W-1:0];
            REG_IM_STEP:  im_step_ff  <= pwdata[STEP_W-1:0];
            REG_MAX_ITER: max_iter_ff <= pwdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      unique case (index)
         REG_MIN_RE:   prdata = min_re_ff;
         REG_MAX_IM:   prdata = max_im_ff;
         REG_RE_STEP:  prdata = {{(DATA_W-STEP_W){1'b0}}, re_step_ff};
         REG_IM_STEP:  prdata = {{(DATA_W-STEP_W){1'b0}}, im_step_ff};
         REG_MAX_ITER: prdata = {{(DATA_W-CNT_W){1'b0}}, max_iter_ff};
         default:      prdata = '0;
      endcase
   end

   assign cfg.min_re   = min_re_ff;
   assign cfg.max_im   = max_im_ff;
   assign cfg.re_step  = re_step_ff;
   assign cfg.im_step  = im_step_ff;
   assign cfg.max_iter = max_iter_ff;

endmodule

[rtl/mbp_front.sv]
// Front end: accepts pixel items and maps the coordinate to the point c.
module mbp_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [mbp_pkg::COORD_W-1:0] req_column,
   input  logic [mbp_pkg::COORD_W-1:0] req_row,
   input  mbp_pkg::cfg_type            cfg,
   input  mbp_pkg::qstat_type          q_stat,
   output logic                        push,
   output mbp_pkg::item_type           push_item
);
   import mbp_pkg::*;

   logic               fv_ff;
   logic [COORD_W-1:0] col_ff;
   logic [COORD_W-1:0] row_ff;
   logic [SPAN_W-1:0]  pre_ff;
   logic [SPAN_W-1:0]  pim_ff;
   logic               accept;
   logic [Z_W-1:0]     re_sum;
   logic [Z_W-1:0]     im_diff;

   // Reserve a queue slot for the item held in the product stage
   assign busy   = fv_ff ? q_stat.one_left : q_stat.full;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= 1'b0;
      end else begin
         fv_ff <= accept;
      end
   end

   // Form column and row offsets
   always_ff @(posedge clock) begin
      if (accept) begin
         col_ff <= req_column;
         row_ff <= req_row;
         pre_ff <= req_column * cfg.re_step;
         pim_ff <= req_row * cfg.im_step;
      end
   end

   // Add the offsets to the image edges and push
   assign re_sum  = {{(Z_W-EDGE_W){cfg.min_re[EDGE_W-1]}}, cfg.min_re}
                    + {{(Z_W-SPAN_W){1'b0}}, pre_ff};
   assign im_diff = {{(Z_W-EDGE_W){cfg.max_im[EDGE_W-1]}}, cfg.max_im}
                    - {{(Z_W-SPAN_W){1'b0}}, pim_ff};

   assign push             = fv_ff;
   assign push_item.column = col_ff;
   assign push_item.row    = row_ff;
   assign push_item.c_re   = re_sum;
   assign push_item.c_im   = im_diff;

endmodule

[rtl/mbp_queue.sv]
// Short item queue between the front end and the iteration engine.
module mbp_queue #(
   parameter int DEPTH = mbp_pkg::MBP_QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mbp_pkg::item_type  push_item,
   input  logic               pop,
   output mbp_pkg::item_type  head_item,
   output mbp_pkg::qstat_type q_stat
);
   import mbp_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int QC_W  = $clog2(DEPTH + 1);

   item_type          entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [QC_W-1:0]   count_ff;

   // Store pushed items
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   assign head_item       = entry_ff[rd_ptr_ff];
   assign q_stat.empty    = (count_ff == '0);
   assign q_stat.full     = (count_ff == QC_W'(DEPTH));
   assign q_stat.one_left = (count_ff >= QC_W'(DEPTH - 1));

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QC_W'(DEPTH))
      else $error("queue count above depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!q_stat.full || pop))
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty)
      else $error("pop from empty queue");

endmodule

[rtl/mbp_engine.sv]
// Iteration engine: runs z = z^2 + c on a shared squaring unit, square then update.
module mbp_engine (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [mbp_pkg::CNT_W-1:0]   max_iter,
   input  mbp_pkg::qstat_type          q_stat,
   input  mbp_pkg::item_type           head_item,
   output logic                        pop,
   output logic                        rsp_valid,
   output logic [mbp_pkg::COORD_W-1:0] rsp_out_column,
   output logic [mbp_pkg::COORD_W-1:0] rsp_out_row,
   output logic                        rsp_inside_res
);
   import mbp_pkg::*;

   eng_state_type         state_ff;
   eng_state_type         state_in;
   logic signed [Z_W-1:0] zr_ff;
   logic signed [Z_W-1:0] zi_ff;
   logic signed [Z_W-1:0] cre_ff;
   logic signed [Z_W-1:0] cim_ff;
   logic [COORD_W-1:0]    col_ff;
   logic [COORD_W-1:0]    row_ff;
   logic [CNT_W-1:0]      n_ff;
   logic [SQ_W-1:0]       r2_ff;
   logic [SQ_W-1:0]       i2_ff;
   logic [CROSS_W-1:0]    cross_ff;
   logic                  neg_ff;
   logic                  big_ff;
   logic                  rsp_valid_ff;
   logic [COORD_W-1:0]    rsp_col_ff;
   logic [COORD_W-1:0]    rsp_row_ff;
   logic                  rsp_inside_ff;

   logic                  load;
   logic                  step;
   logic                  rsp_valid_in;
   logic                  rsp_inside_in;
   logic [COORD_W-1:0]    rsp_col_in;
   logic [COORD_W-1:0]    rsp_row_in;

   logic [Z_W-1:0]        ar;
   logic [Z_W-1:0]        ai;
   logic [MAG_W-1:0]      mr;
   logic [MAG_W-1:0]      mi;
   logic [PROD_W-1:0]     p_rr;
   logic [PROD_W-1:0]     p_ii;
   logic [PROD_W-1:0]     p_ri;
   logic [SQ_W:0]         sq_sum;
   logic                  escape;
   logic [CNT_W:0]        n_inc;
   logic                  last;
   logic signed [Z_W-1:0] r2_x;
   logic signed [Z_W-1:0] i2_x;
   logic signed [Z_W-1:0] cross_x;
   logic signed [Z_W-1:0] zr_new;
   logic signed [Z_W-1:0] zi_new;

   // Square stage: magnitudes, range test and the three products
   assign ar   = zr_ff[Z_W-1] ? Z_W'(0) - unsigned'(zr_ff) : unsigned'(zr_ff);
   assign ai   = zi_ff[Z_W-1] ? Z_W'(0) - unsigned'(zi_ff) : unsigned'(zi_ff);
   assign mr   = ar[MAG_W-1:0];
   assign mi   = ai[MAG_W-1:0];
   assign p_rr = mr * mr;
   assign p_ii = mi * mi;
   assign p_ri = mr * mi;

   always_ff @(posedge clock) begin
      r2_ff    <= p_rr[FRAC_BITS+SQ_W-1:FRAC_BITS];
      i2_ff    <= p_ii[FRAC_BITS+SQ_W-1:FRAC_BITS];
      cross_ff <= p_ri[FRAC_BITS+CROSS_W-2:FRAC_BITS-1];
      neg_ff   <= zr_ff[Z_W-1] ^ zi_ff[Z_W-1];
      big_ff   <= (ar > TWO_MAG) || (ai > TWO_MAG);
   end

   // Update stage: escape test and the next z
   assign sq_sum  = {1'b0, r2_ff} + {1'b0, i2_ff};
   assign escape  = big_ff || (sq_sum > FOUR_SUM);
   assign n_inc   = {1'b0, n_ff} + 1'b1;
   assign last    = (n_inc == {1'b0, max_iter});
   assign r2_x    = {{(Z_W-SQ_W){1'b0}}, r2_ff};
   assign i2_x    = {{(Z_W-SQ_W){1'b0}}, i2_ff};
   assign cross_x = {{(Z_W-CROSS_W){1'b0}}, cross_ff};
   assign zi_new  = (neg_ff ? -cross_x : cross_x) + cim_ff;
   assign zr_new  = r2_x - i2_x + cre_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ENG_IDLE: begin
            if (!q_stat.empty && (max_iter != '0)) begin
               state_in = ENG_MUL;
            end
         end
         ENG_MUL: state_in = ENG_UPD;
         ENG_UPD: begin
            if (escape || last) begin
               state_in = ENG_IDLE;
            end else begin
               state_in = ENG_MUL;
            end
         end
         default: state_in = ENG_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      pop           = 1'b0;
      load          = 1'b0;
      step          = 1'b0;
      rsp_valid_in  = 1'b0;
      rsp_inside_in = 1'b0;
      rsp_col_in    = col_ff;
      rsp_row_in    = row_ff;
      unique case (state_ff)
         ENG_IDLE: begin
            rsp_col_in = head_item.column;
            rsp_row_in = head_item.row;
            if (!q_stat.empty) begin
               pop  = 1'b1;
               load = 1'b1;
               // zero limit: no test, report inside at once
               if (max_iter == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_inside_in = 1'b1;
               end
            end
         end
         ENG_MUL: ;
         ENG_UPD: begin
            if (escape) begin
               rsp_valid_in = 1'b1;
            end else begin
               step = 1'b1;
               if (last) begin
                  rsp_valid_in  = 1'b1;
                  rsp_inside_in = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ENG_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load a new point or advance z
   always_ff @(posedge clock) begin
      if (load) begin
         zr_ff  <= head_item.c_re;
         zi_ff  <= head_item.c_im;
         cre_ff <= head_item.c_re;
         cim_ff <= head_item.c_im;
         col_ff <= head_item.column;
         row_ff <= head_item.row;
         n_ff   <= '0;
      end else if (step) begin
         zr_ff <= zr_new;
         zi_ff <= zi_new;
         n_ff  <= n_inc[CNT_W-1:0];
      end
   end

   // Hold the result for its strobe cycle
   always_ff @(posedge clock) begin
      if (rsp_valid_in) begin
         rsp_col_ff    <= rsp_col_in;
         rsp_row_ff    <= rsp_row_in;
         rsp_inside_ff <= rsp_inside_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_column = rsp_col_ff;
   assign rsp_out_row    = rsp_row_ff;
   assign rsp_inside_res = rsp_inside_ff;

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) == ENG_UPD || $past(state_ff) == ENG_IDLE))
      else $error("result strobe from wrong state");

   a_upd_after_mul: assert property (@(posedge clock) disable iff (reset)
      state_ff == ENG_UPD |-> $past(state_ff) == ENG_MUL)
      else $error("update stage without square stage");

   a_mul_single: assert property (@(posedge clock) disable iff (reset)
      state_ff == ENG_MUL |-> $past(state_ff) != ENG_MUL)
      else $error("square stage repeated");

endmodule

[rtl/mandelbrot_pixel_membership_top.sv]
// Top level of the Mandelbrot pixel membership block.
// An accepted item passes the front-end product register and the queue to the
//   engine; its result strobes after a square and an update stage per iteration run,
//   up to the escape step or the limit. The engine works on one item at a time on the
//   shared multiplier set; the queue lets start be taken meanwhile.
// Reset clears the queue, the engine state and the strobe, and loads register defaults.
module mandelbrot_pixel_membership_top #(
   parameter int QUEUE_DEPTH = mbp_pkg::MBP_QUEUE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [mbp_pkg::COORD_W-1:0] req_column,
   input  logic [mbp_pkg::COORD_W-1:0] req_row,
   output logic                        rsp_valid,
   output logic [mbp_pkg::COORD_W-1:0] rsp_out_column,
   output logic [mbp_pkg::COORD_W-1:0] rsp_out_row,
   output logic                        rsp_inside_res,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [mbp_pkg::ADDR_W-1:0]  paddr,
   input  logic [mbp_pkg::DATA_W-1:0]  pwdata,
   output logic [mbp_pkg::DATA_W-1:0]  prdata,
   output logic                        pready
);
   import mbp_pkg::*;

   cfg_type   cfg;
   qstat_type q_stat;
   item_type  push_item;
   item_type  head_item;
   logic      push;
   logic      pop;

   mbp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   mbp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_column (req_column),
      .req_row    (req_row),
      .cfg        (cfg),
      .q_stat     (q_stat),
      .push       (push),
      .push_item  (push_item)
   );

   mbp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .q_stat    (q_stat)
   );

   mbp_engine u_engine (
      .clock          (clock),
      .reset          (reset),
      .max_iter       (cfg.max_iter),
      .q_stat         (q_stat),
      .head_item      (head_item),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_out_column (rsp_out_column),
      .rsp_out_row    (rsp_out_row),
      .rsp_inside_res (rsp_inside_res)
   );

endmodule
